// ----- src/upsg_pkg.sv -----
package upsg_pkg;

   localparam int UTIL_W         = 14;
   localparam int SIZE_W         = 8;
   localparam int DEPTH_W        = 16;
   localparam int CSR_INDEX_W    = 3;
   localparam int CSR_DATA_W     = 16;
   localparam int WINDOW_DEFAULT = 100;

   localparam logic [UTIL_W-1:0]  HIGH_THRESHOLD_RESET     = UTIL_W'(8000);
   localparam logic [UTIL_W-1:0]  LOW_THRESHOLD_RESET      = UTIL_W'(3000);
   localparam logic [SIZE_W-1:0]  MIN_SIZE_RESET           = SIZE_W'(2);
   localparam logic [SIZE_W-1:0]  MAX_SIZE_RESET           = SIZE_W'(32);
   localparam logic [DEPTH_W-1:0] FIRST_QUEUE_LIMIT_RESET  = DEPTH_W'(10);
   localparam logic [DEPTH_W-1:0] SECOND_QUEUE_LIMIT_RESET = DEPTH_W'(20);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_HIGH_THRESHOLD     = 3'd0,
      CSR_LOW_THRESHOLD      = 3'd1,
      CSR_MIN_SIZE           = 3'd2,
      CSR_MAX_SIZE           = 3'd3,
      CSR_FIRST_QUEUE_LIMIT  = 3'd4,
      CSR_SECOND_QUEUE_LIMIT = 3'd5
   } csr_index_type;

endpackage

// ----- src/upsg_req_if.sv -----
interface upsg_req_if import upsg_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [UTIL_W-1:0]  utilization;
   logic [SIZE_W-1:0]  pool_size;
   logic [DEPTH_W-1:0] first_queue_depth;
   logic [DEPTH_W-1:0] second_queue_depth;

   modport source (output valid, output utilization, output pool_size,
                   output first_queue_depth, output second_queue_depth, input ready);
   modport sink   (input valid, input utilization, input pool_size,
                   input first_queue_depth, input second_queue_depth, output ready);
endinterface

// ----- src/upsg_rsp_if.sv -----
interface upsg_rsp_if import upsg_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [SIZE_W-1:0] new_pool_size;

   modport source (output valid, output new_pool_size, input ready);
   modport sink   (input valid, input new_pool_size, output ready);
endinterface

// ----- src/upsg_cell.sv -----
module upsg_cell import upsg_pkg::*; (
   input  logic              clock,
   input  logic              shift_en,
   input  logic [UTIL_W-1:0] sample_in,
   output logic [UTIL_W-1:0] sample_out
);

   logic [UTIL_W-1:0] sample_ff;

   // no reset: the fill count tells which cells hold a sample
   always_ff @(posedge clock) begin
      if (shift_en) begin
         sample_ff <= sample_in;
      end
   end

   assign sample_out = sample_ff;

endmodule

// ----- src/upsg_window.sv -----
module upsg_window import upsg_pkg::*; #(
   parameter int Window = WINDOW_DEFAULT,
   parameter int FillW  = $clog2(Window + 1),
   parameter int SumW   = UTIL_W + FillW
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              shift_en,
   input  logic [UTIL_W-1:0] sample_in,
   output logic [SumW-1:0]   sum_out,
   output logic [FillW-1:0]  fill_out
);

   localparam logic [FillW-1:0] FillMax = FillW'(Window);

   logic [UTIL_W-1:0] tap [Window+1];
   logic [SumW-1:0]   sum_ff;
   logic [SumW-1:0]   sum_in;
   logic [FillW-1:0]  fill_ff;
   logic [FillW-1:0]  fill_in;
   logic              full;

   assign tap[0] = sample_in;

   for (genvar i = 0; i < Window; i++) begin : g_cell
      upsg_cell u_cell (
         .clock      (clock),
         .shift_en   (shift_en),
         .sample_in  (tap[i]),
         .sample_out (tap[i+1])
      );
   end

   assign full = (fill_ff == FillMax);

   // drop the oldest sample once the window is full, then add the new one
   always_comb begin
      sum_in  = sum_ff;
      fill_in = fill_ff;
      if (shift_en) begin
         if (full) begin
            sum_in = sum_ff - SumW'(tap[Window]) + SumW'(sample_in);
         end else begin
            sum_in  = sum_ff + SumW'(sample_in);
            fill_in = fill_ff + FillW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff  <= '0;
         fill_ff <= '0;
      end else begin
         sum_ff  <= sum_in;
         fill_ff <= fill_in;
      end
   end

   assign sum_out  = sum_ff;
   assign fill_out = fill_ff;

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FillMax)
      else $error("fill count beyond window depth");

   a_fill_grows: assert property (@(posedge clock) disable iff (reset)
      shift_en && !full |=> fill_ff == $past(fill_ff) + FillW'(1))
      else $error("fill count did not advance on request");

   a_empty_sum: assert property (@(posedge clock) disable iff (reset)
      fill_ff == '0 |-> sum_ff == '0)
      else $error("nonzero sum with empty window");

endmodule

// ----- src/utilization_pool_size_governor.sv -----
// A request passes stage one, stage two and the output register. Throughput: one request
// per cycle while the output slot is free or drains; the window is a shift chain of sample
// cells with a running sum, so each request costs one shift and one add/subtract.
// Reset (synchronous, active high) clears the fill count, the sum, the pipeline valids and
// loads the threshold, size and queue limit registers with their defaults; the sample cells
// are not cleared and are never read before being written.
module utilization_pool_size_governor import upsg_pkg::*; #(
   parameter int Window = WINDOW_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   upsg_req_if.sink               req_ch,
   upsg_rsp_if.source             rsp_ch,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int FillW = $clog2(Window + 1);
   localparam int SumW  = UTIL_W + FillW;

   // configuration
   logic [UTIL_W-1:0]  high_thr_ff;
   logic [UTIL_W-1:0]  low_thr_ff;
   logic [SIZE_W-1:0]  min_size_ff;
   logic [SIZE_W-1:0]  max_size_ff;
   logic [DEPTH_W-1:0] first_limit_ff;
   logic [DEPTH_W-1:0] second_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         high_thr_ff     <= HIGH_THRESHOLD_RESET;
         low_thr_ff      <= LOW_THRESHOLD_RESET;
         min_size_ff     <= MIN_SIZE_RESET;
         max_size_ff     <= MAX_SIZE_RESET;
         first_limit_ff  <= FIRST_QUEUE_LIMIT_RESET;
         second_limit_ff <= SECOND_QUEUE_LIMIT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_HIGH_THRESHOLD:     high_thr_ff     <= csr_wdata[UTIL_W-1:0];
            CSR_LOW_THRESHOLD:      low_thr_ff      <= csr_wdata[UTIL_W-1:0];
            CSR_MIN_SIZE:           min_size_ff     <= csr_wdata[SIZE_W-1:0];
            CSR_MAX_SIZE:           max_size_ff     <= csr_wdata[SIZE_W-1:0];
            CSR_FIRST_QUEUE_LIMIT:  first_limit_ff  <= csr_wdata[DEPTH_W-1:0];
            CSR_SECOND_QUEUE_LIMIT: second_limit_ff <= csr_wdata[DEPTH_W-1:0];
            default: ;
         endcase
      end
   end

   // handshake: the whole pipeline moves when the output slot is free or drains
   logic advance;
   logic accept;
   logic out_v_ff;

   assign advance      = !out_v_ff || rsp_ch.ready;
   assign req_ch.ready = advance;
   assign accept       = req_ch.valid && advance;

   // window: updated sum and fill count line up with stage one
   logic [SumW-1:0]  win_sum;
   logic [FillW-1:0] win_fill;

   upsg_window #(
      .Window (Window),
      .FillW  (FillW),
      .SumW   (SumW)
   ) u_window (
      .clock     (clock),
      .reset     (reset),
      .shift_en  (accept),
      .sample_in (req_ch.utilization),
      .sum_out   (win_sum),
      .fill_out  (win_fill)
   );

   logic q_over;
   assign q_over = (req_ch.first_queue_depth > first_limit_ff)
                || (req_ch.second_queue_depth > second_limit_ff);

   // stage one
   logic              s1_v_ff;
   logic [SIZE_W-1:0] s1_cur_ff;
   logic              s1_q_ff;

   // stage two
   logic              s2_v_ff;
   logic [SIZE_W-1:0] s2_cur_ff;
   logic              s2_q_ff;
   logic [SumW-1:0]   s2_sum_ff;
   logic [SumW-1:0]   s2_hi_ff;
   logic [SumW-1:0]   s2_lo_ff;
   logic [SumW-1:0]   hi_lim_in;
   logic [SumW-1:0]   lo_lim_in;

   assign hi_lim_in = {{FillW{1'b0}}, high_thr_ff} * {{UTIL_W{1'b0}}, win_fill};
   assign lo_lim_in = {{FillW{1'b0}}, low_thr_ff} * {{UTIL_W{1'b0}}, win_fill};

   // output stage
   logic [SIZE_W-1:0] out_size_ff;
   logic [SIZE_W-1:0] out_size_in;
   logic              out_q_ff;

   logic              grow;
   logic              shrink;
   logic [SIZE_W:0]   grown;
   logic [SIZE_W:0]   bumped;
   logic [SIZE_W-1:0] ruled;

   always_comb begin
      grow   = (s2_sum_ff > s2_hi_ff) && (s2_cur_ff < max_size_ff);
      shrink = (s2_sum_ff < s2_lo_ff) && (s2_cur_ff > min_size_ff);
      grown  = {1'b0, s2_cur_ff} + (SIZE_W+1)'(2);
      if (grow) begin
         ruled = (grown > {1'b0, max_size_ff}) ? max_size_ff : grown[SIZE_W-1:0];
      end else if (shrink) begin
         ruled = s2_cur_ff - SIZE_W'(1);
      end else begin
         ruled = s2_cur_ff;
      end
      bumped      = {1'b0, ruled} + (SIZE_W+1)'(1);
      out_size_in = ruled;
      if (s2_q_ff) begin
         out_size_in = (bumped > {1'b0, max_size_ff}) ? max_size_ff : bumped[SIZE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else if (advance) begin
         s1_v_ff  <= accept;
         s2_v_ff  <= s1_v_ff;
         out_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_cur_ff   <= req_ch.pool_size;
         s1_q_ff     <= q_over;
         s2_cur_ff   <= s1_cur_ff;
         s2_q_ff     <= s1_q_ff;
         s2_sum_ff   <= win_sum;
         s2_hi_ff    <= hi_lim_in;
         s2_lo_ff    <= lo_lim_in;
         out_size_ff <= out_size_in;
         out_q_ff    <= s2_q_ff;
      end
   end

   assign rsp_ch.valid         = out_v_ff;
   assign rsp_ch.new_pool_size = out_size_ff;

   a_queue_caps_size: assert property (@(posedge clock) disable iff (reset)
      out_v_ff && out_q_ff |-> out_size_ff <= max_size_ff)
      else $error("queue bump exceeded max size");

   a_stall_holds_pipe: assert property (@(posedge clock) disable iff (reset)
      !advance |=> s1_v_ff == $past(s1_v_ff) && s2_v_ff == $past(s2_v_ff))
      else $error("pipeline moved while output stalled");

   a_step_bounded: assert property (@(posedge clock) disable iff (reset)
      s2_v_ff && !s2_q_ff |-> {1'b0, out_size_in} <= {1'b0, s2_cur_ff} + (SIZE_W+1)'(2))
      else $error("size grew by more than two");

endmodule
